// ===== rtl/rrfr_pkg.sv =====
// Shared types, constants and a helper function for the radio reply frame receiver.
package rrfr_pkg;

  localparam int MAX_PAYLOAD = 128;
  localparam int BCD_BYTES   = 5;

  localparam logic [7:0] BYTE_PRE = 8'hFE;
  localparam logic [7:0] BYTE_END = 8'hFD;
  localparam logic [7:0] BYTE_ACK = 8'hFB;
  localparam logic [7:0] BYTE_NAK = 8'hFA;

  localparam logic [1:0] REG_OWN_ADDRESS     = 2'd0;
  localparam logic [1:0] REG_RADIO_ADDRESS   = 2'd1;
  localparam logic [1:0] REG_SKIP_SUBCOMMAND = 2'd2;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_NAK      = 3'd2,
    KIND_DATA_END = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [6:0] {
    PH_PRE1 = 7'b0000001,
    PH_PRE2 = 7'b0000010,
    PH_TO   = 7'b0000100,
    PH_FROM = 7'b0001000,
    PH_CMD  = 7'b0010000,
    PH_SUB  = 7'b0100000,
    PH_DATA = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] radio_address;
    logic       skip_subcommand;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  payload_length;
    logic [33:0] bcd_value;
    logic        bcd_bad_digit;
    logic        last;
  } result_t;

  // Weight of the k-th payload byte, 100^k reduced to 34 bits.
  function automatic logic [33:0] decade_weight(input logic [2:0] k);
    logic [33:0] w;
    case (k)
      3'd0: w = 34'd1;
      3'd1: w = 34'd100;
      3'd2: w = 34'd10000;
      3'd3: w = 34'd1000000;
      3'd4: w = 34'd100000000;
      3'd5: w = 34'd10000000000;
      3'd6: w = 34'd3567587328;
      3'd7: w = 34'd13161349120;
      default: w = 34'd1;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/rrfr_parse.sv =====
// Frame parser: phase tracking, address filter, payload count and BCD accumulation.
module rrfr_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           rx_byte,
  input  rrfr_pkg::cfg_t       cfg,
  output rrfr_pkg::result_t    result
);

  rrfr_pkg::phase_t phase, phase_next;
  logic        frame_kept, frame_kept_next;
  logic [7:0]  command_code, command_code_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [33:0] bcd_acc, bcd_acc_next;
  logic        digit_error, digit_error_next;
  logic        overflowed, overflowed_next;

  logic [3:0]  hi_nib;
  logic [3:0]  lo_nib;
  logic [7:0]  digit_pair;
  logic [33:0] weighted;
  logic        emit_payload;
  logic        emit_end;

  assign hi_nib     = rx_byte[7:4];
  assign lo_nib     = rx_byte[3:0];
  assign digit_pair = 8'(hi_nib) * 8'd10 + 8'(lo_nib);
  assign weighted   = 34'(42'(digit_pair) *
                          42'(rrfr_pkg::decade_weight(payload_count[2:0])));

  always_comb begin
    phase_next         = phase;
    frame_kept_next    = frame_kept;
    command_code_next  = command_code;
    payload_count_next = payload_count;
    bcd_acc_next       = bcd_acc;
    digit_error_next   = digit_error;
    overflowed_next    = overflowed;
    emit_payload       = 1'b0;
    emit_end           = 1'b0;
    case (phase)
      rrfr_pkg::PH_PRE1: begin
        if (rx_byte == rrfr_pkg::BYTE_PRE) phase_next = rrfr_pkg::PH_PRE2;
      end
      rrfr_pkg::PH_PRE2: begin
        if (rx_byte == rrfr_pkg::BYTE_PRE) begin
          phase_next         = rrfr_pkg::PH_TO;
          frame_kept_next    = 1'b0;
          command_code_next  = 8'd0;
          payload_count_next = 8'd0;
          bcd_acc_next       = 34'd0;
          digit_error_next   = 1'b0;
          overflowed_next    = 1'b0;
        end else begin
          phase_next = rrfr_pkg::PH_PRE1;
        end
      end
      rrfr_pkg::PH_TO: begin
        if (rx_byte == rrfr_pkg::BYTE_END) begin
          phase_next = rrfr_pkg::PH_PRE1;
        end else begin
          frame_kept_next = (rx_byte == cfg.own_address);
          phase_next      = rrfr_pkg::PH_FROM;
        end
      end
      rrfr_pkg::PH_FROM: begin
        if (rx_byte == rrfr_pkg::BYTE_END) begin
          phase_next = rrfr_pkg::PH_PRE1;
        end else begin
          frame_kept_next = frame_kept && (rx_byte == cfg.radio_address);
          phase_next      = rrfr_pkg::PH_CMD;
        end
      end
      rrfr_pkg::PH_CMD: begin
        if (rx_byte == rrfr_pkg::BYTE_END) begin
          phase_next = rrfr_pkg::PH_PRE1;
        end else begin
          command_code_next = rx_byte;
          phase_next = cfg.skip_subcommand ? rrfr_pkg::PH_SUB : rrfr_pkg::PH_DATA;
        end
      end
      rrfr_pkg::PH_SUB: begin
        if (rx_byte == rrfr_pkg::BYTE_END) begin
          phase_next = rrfr_pkg::PH_PRE1;
          emit_end   = frame_kept;
        end else begin
          phase_next = rrfr_pkg::PH_DATA;
        end
      end
      rrfr_pkg::PH_DATA: begin
        if (rx_byte == rrfr_pkg::BYTE_END) begin
          phase_next = rrfr_pkg::PH_PRE1;
          emit_end   = frame_kept;
        end else if (payload_count >= 8'(rrfr_pkg::MAX_PAYLOAD)) begin
          overflowed_next = 1'b1;
        end else begin
          if (payload_count < 8'(rrfr_pkg::BCD_BYTES)) begin
            if (hi_nib > 4'd9 || lo_nib > 4'd9) digit_error_next = 1'b1;
            bcd_acc_next = bcd_acc + weighted;
          end
          payload_count_next = payload_count + 8'd1;
          emit_payload       = frame_kept;
        end
      end
      default: begin
        phase_next = rrfr_pkg::PH_PRE1;
      end
    endcase
  end

  always_comb begin
    result.valid          = emit_payload || emit_end;
    result.data_byte      = emit_end ? command_code : rx_byte;
    result.payload_length = payload_count_next;
    result.bcd_value      = bcd_acc_next;
    result.bcd_bad_digit  = digit_error_next;
    result.last           = emit_end;
    if (!emit_end) begin
      result.kind = rrfr_pkg::KIND_PAYLOAD;
    end else if (overflowed) begin
      result.kind = rrfr_pkg::KIND_OVERFLOW;
    end else if (command_code == rrfr_pkg::BYTE_ACK) begin
      result.kind = rrfr_pkg::KIND_ACK;
    end else if (command_code == rrfr_pkg::BYTE_NAK) begin
      result.kind = rrfr_pkg::KIND_NAK;
    end else begin
      result.kind = rrfr_pkg::KIND_DATA_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rrfr_pkg::PH_PRE1;
      frame_kept    <= 1'b0;
      command_code  <= 8'd0;
      payload_count <= 8'd0;
      bcd_acc       <= 34'd0;
      digit_error   <= 1'b0;
      overflowed    <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      frame_kept    <= frame_kept_next;
      command_code  <= command_code_next;
      payload_count <= payload_count_next;
      bcd_acc       <= bcd_acc_next;
      digit_error   <= digit_error_next;
      overflowed    <= overflowed_next;
    end
  end

endmodule

// ===== rtl/radio_reply_frame_receiver.sv =====
// Top level of the radio reply frame receiver: input stage, parser and result register.
//
// Channel  Direction  Carries
// s_axis   in         received bytes, one per beat
// m_axis   out        payload bytes and frame-end status results
// cfg      in         register writes (index, data)
//
// A byte is registered on entry and parsed into the result register once that register is empty or
// being drained; its result, if any, is then offered on m_axis.
// One byte is accepted every cycle while the result register drains.
// Reset clears the parser to wait for a preamble and loads the default addresses.
// A stall on m_axis holds the result and backs up into s_axis once the input register holds a byte.
module radio_reply_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] data_byte, [15:8] payload_length,
                                      // [49:16] bcd_value, [50] bcd_bad_digit, zero fill
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;
  rrfr_pkg::cfg_t     cfg;
  rrfr_pkg::result_t  result;
  rrfr_pkg::result_t  out_reg;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_reg.valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address     <= 8'hE0;
      cfg.radio_address   <= 8'h00;
      cfg.skip_subcommand <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrfr_pkg::REG_OWN_ADDRESS:     cfg.own_address     <= cfg_data;
        rrfr_pkg::REG_RADIO_ADDRESS:   cfg.radio_address   <= cfg_data;
        rrfr_pkg::REG_SKIP_SUBCOMMAND: cfg.skip_subcommand <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_byte <= s_axis_tdata;
  end

  rrfr_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
    end else if (advance) begin
      out_reg.valid <= result.valid;
    end else if (m_axis_tready) begin
      out_reg.valid <= 1'b0;
    end
    if (advance && result.valid) begin
      out_reg.kind           <= result.kind;
      out_reg.data_byte      <= result.data_byte;
      out_reg.payload_length <= result.payload_length;
      out_reg.bcd_value      <= result.bcd_value;
      out_reg.bcd_bad_digit  <= result.bcd_bad_digit;
      out_reg.last           <= result.last;
    end
  end

  assign m_axis_tvalid = out_reg.valid;
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tlast  = out_reg.last;
  assign m_axis_tdata  = {5'd0, out_reg.bcd_bad_digit, out_reg.bcd_value,
                          out_reg.payload_length, out_reg.data_byte};

endmodule

// ===== rtl/rrfr_checker.sv =====
// Port-level assertions for the radio reply frame receiver, with the bind to the top level.
module rrfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == rrfr_pkg::KIND_PAYLOAD)
    else $error("payload beat carries a frame-end kind");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == rrfr_pkg::KIND_ACK
      || m_axis_tuser == rrfr_pkg::KIND_NAK || m_axis_tuser == rrfr_pkg::KIND_DATA_END
      || m_axis_tuser == rrfr_pkg::KIND_OVERFLOW)
    else $error("frame-end beat carries an invalid kind");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:8] <= 8'(rrfr_pkg::MAX_PAYLOAD))
    else $error("payload length beyond the maximum");

  a_overflow_length: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == rrfr_pkg::KIND_OVERFLOW
      |-> m_axis_tdata[15:8] == 8'(rrfr_pkg::MAX_PAYLOAD))
    else $error("overflow reported below the maximum length");

endmodule

bind radio_reply_frame_receiver rrfr_checker u_rrfr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
